[rtl/recent_message_dedup_filter_assert.svh]
// Assertion macros for the duplicate filter.
// Included by the controller and the datapath; no other dependencies.
`ifndef RECENT_MESSAGE_DEDUP_FILTER_ASSERT_SVH
`define RECENT_MESSAGE_DEDUP_FILTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RMDF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rmdf assertion failed");

// next-cycle implication, disabled in reset
`define RMDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rmdf assertion failed");

`endif

[rtl/rmdf_pkg.sv]
// Shared types and constants for the duplicate message filter.
// No dependencies; imported by all rtl modules.
package rmdf_pkg;

    localparam int LIMIT_W     = 9;
    localparam int LIMIT_RESET = 200;
    localparam int TYPE_W      = 2;
    localparam int ID_W        = 16;
    localparam int OUT_TDATA_W = 8;

    // controller -> datapath
    typedef struct packed {
        logic cfg_write;   // limit write, clears history
        logic load_key;    // capture input word, restart search
        logic issue_read;  // read key store at search index
        logic store_new;   // append key at write pointer
        logic set_result;
        logic result_dup;
        logic load_out;    // move result into output register
    } rmdf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic search_done; // every valid entry has been read
        logic rd_pending;  // read data in flight
        logic hit;         // read data matches key
    } rmdf_status_t;

endpackage

[rtl/rmdf_ctrl.sv]
// Controller for the duplicate filter: sequences search, insert and result.
// Depends on rmdf_pkg and recent_message_dedup_filter_assert.svh.
`include "recent_message_dedup_filter_assert.svh"

module rmdf_ctrl
    import rmdf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  rmdf_status_t status,
    output rmdf_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_RESP   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = (state_reg == ST_IDLE);
    // config write takes precedence over a new word
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.cfg_write = cfg_valid && cfg_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load_key = 1'b1;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (status.hit) begin
                    cmd.set_result = 1'b1;
                    cmd.result_dup = 1'b1;
                    state_next     = ST_RESP;
                end else if (status.search_done && !status.rd_pending) begin
                    cmd.store_new  = 1'b1;
                    cmd.set_result = 1'b1;
                    state_next     = ST_RESP;
                end else if (!status.search_done) begin
                    cmd.issue_read = 1'b1;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `RMDF_ASSERT_NOW(a_no_dual_accept, aclk, aresetn, s_tvalid && s_tready, !cmd.cfg_write)
    `RMDF_ASSERT_NOW(a_out_free_on_load, aclk, aresetn, cmd.load_out, out_free)
    `RMDF_ASSERT_NOW(a_read_in_range, aclk, aresetn, cmd.issue_read, !status.search_done)
    `RMDF_ASSERT_NEXT(a_result_then_resp, aclk, aresetn, cmd.set_result, state_reg == ST_RESP)

endmodule

[rtl/rmdf_datapath.sv]
// Datapath for the duplicate filter: key store memory, search index,
// write pointer, fill count, limit register and result registers.
// Depends on rmdf_pkg and recent_message_dedup_filter_assert.svh.
`include "recent_message_dedup_filter_assert.svh"

module rmdf_datapath
    import rmdf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 256,
    parameter int SENDER_BITS   = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rmdf_cmd_t                     cmd,
    output rmdf_status_t                  status,
    input  logic [SENDER_BITS+TYPE_W+ID_W-1:0] key_in,
    input  logic [LIMIT_W-1:0]            cfg_data,
    output logic                          out_dup
);

    localparam int KW = SENDER_BITS + TYPE_W + ID_W;
    localparam int PW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic [KW-1:0]      key_store [HISTORY_DEPTH];
    logic [KW-1:0]      key_reg;
    logic [KW-1:0]      rd_reg;
    logic               rd_vld_reg;
    logic [CW-1:0]      idx_reg;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               dup_reg;
    logic               out_dup_reg;

    logic [31:0]        lim_wide;
    logic [CW-1:0]      lim_eff;
    logic [PW-1:0]      wp_eff;
    logic [CW-1:0]      wp_inc;

    // limit of zero acts as one; above depth saturates
    always_comb begin
        if (limit_reg == '0) begin
            lim_wide = 32'd1;
        end else if (32'(limit_reg) > 32'(HISTORY_DEPTH)) begin
            lim_wide = 32'(HISTORY_DEPTH);
        end else begin
            lim_wide = 32'(limit_reg);
        end
    end
    assign lim_eff = lim_wide[CW-1:0];

    always_comb begin
        wp_eff = (CW'(wp_reg) >= lim_eff) ? '0 : wp_reg;
        wp_inc = CW'(wp_eff) + CW'(1);
        wp_next    = (wp_inc >= lim_eff) ? '0 : wp_inc[PW-1:0];
        count_next = (count_reg < lim_eff) ? count_reg + CW'(1) : count_reg;
    end

    assign status.search_done = (idx_reg == count_reg);
    assign status.rd_pending  = rd_vld_reg;
    assign status.hit         = rd_vld_reg && (rd_reg == key_reg);
    assign out_dup            = out_dup_reg;

    // key store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.store_new) begin
            key_store[wp_eff] <= key_reg;
        end
        if (cmd.issue_read) begin
            rd_reg <= key_store[idx_reg[PW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg <= key_in;
        end
        if (cmd.set_result) begin
            dup_reg <= cmd.result_dup;
        end
        if (cmd.load_out) begin
            out_dup_reg <= dup_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            idx_reg    <= '0;
            wp_reg     <= '0;
            count_reg  <= '0;
            limit_reg  <= LIMIT_W'(LIMIT_RESET);
        end else begin
            rd_vld_reg <= cmd.issue_read;
            if (cmd.load_key) begin
                idx_reg <= '0;
            end else if (cmd.issue_read) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.cfg_write) begin
                limit_reg <= cfg_data;
                wp_reg    <= '0;
                count_reg <= '0;
            end else if (cmd.store_new) begin
                wp_reg    <= wp_next;
                count_reg <= count_next;
            end
        end
    end

    `RMDF_ASSERT_NOW(a_count_le_limit, aclk, aresetn, 1'b1, count_reg <= lim_eff)
    `RMDF_ASSERT_NOW(a_wp_below_limit, aclk, aresetn, 1'b1, CW'(wp_reg) < lim_eff)
    `RMDF_ASSERT_NEXT(a_store_fills, aclk, aresetn, cmd.store_new, count_reg != '0)

endmodule

[rtl/recent_message_dedup_filter.sv]
// Top level of the recent message duplicate filter.
// Depends on rmdf_pkg, rmdf_ctrl and rmdf_datapath.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata: sender_id, msg_type, message_id
//  m_        out  m_tvalid/m_tready    m_tdata: is_duplicate
//  cfg_      in   cfg_valid/cfg_ready  cfg_data: history_limit
//
// A new key raises m_tvalid once every key held (up to the limit) has been searched;
// a duplicate ends the search at the matching entry and raises m_tvalid from there.
// The search reads the key store memory one entry per cycle.
// Reset empties the history and loads a limit of 200; no clearing pass is needed.
// A result waiting on m_tready holds the block in its result state.
module recent_message_dedup_filter
    import rmdf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 256,
    parameter int SENDER_BITS   = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // sender_id, msg_type, message_id, zero pad
    input  logic [((SENDER_BITS+TYPE_W+ID_W+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // is_duplicate, zero pad
    output logic [OUT_TDATA_W-1:0]       m_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [LIMIT_W-1:0]           cfg_data
);

    localparam int KW = SENDER_BITS + TYPE_W + ID_W;

    rmdf_cmd_t    cmd;
    rmdf_status_t status;
    logic         out_dup;

    rmdf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rmdf_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SENDER_BITS   (SENDER_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .key_in   (s_tdata[KW-1:0]),
        .cfg_data (cfg_data),
        .out_dup  (out_dup)
    );

    assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, out_dup};

endmodule

[tb/sv/recent_message_dedup_filter_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for recent_message_dedup_filter: a directed table, then random phases.
// Checks each result against a local model of the key history. Depends on rmdf_pkg and recent_message_dedup_filter.
module recent_message_dedup_filter_tb;
    import rmdf_pkg::*;

    localparam int HISTORY_DEPTH = 256;
    localparam int SENDER_BITS   = 32;
    localparam int KEY_W         = SENDER_BITS + TYPE_W + ID_W;
    localparam int S_TDATA_W     = ((KEY_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int NUM_PHASES    = 12;

    // last field in the lowest bits
    typedef struct packed {
        logic [ID_W-1:0]        message_id;
        logic [TYPE_W-1:0]      msg_type;
        logic [SENDER_BITS-1:0] sender_id;
    } msg_key_t;

    typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [LIMIT_W-1:0] limit;
        msg_key_t           key;
        logic               typed;
        logic               dup;
    } stim_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LIMIT_W-1:0]     cfg_data  = '0;

    // local copy of the history
    msg_key_t           history_keys [HISTORY_DEPTH];
    int unsigned        hist_wr_ptr;
    int unsigned        hist_count;
    logic [LIMIT_W-1:0] limit_reg;

    logic      pending_dup [$];
    msg_key_t  recent_keys [$];
    stim_row_t directed_rows [$];
    int        recent_cap;
    int        gap_pct;
    int        stall_pct;
    int        holdoff_len;
    int        holdoff_requests;
    int        holdoff_served;
    int        holdoff_left;
    int        fail_count;
    int        cycle_count;
    logic      oldest_dup;

    int phase_limit [NUM_PHASES] = '{3, 1, 16, 2, 511, 8, 0, 256, 5, 31, 200, 4};
    int phase_items [NUM_PHASES] = '{130, 100, 100, 100, 480, 100, 80, 60, 100, 100, 60, 150};

    recent_message_dedup_filter #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .SENDER_BITS  (SENDER_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic int clamp_limit(input logic [LIMIT_W-1:0] v);
        int lim;
        lim = (v == 0) ? 1 : int'(v);
        if (lim > HISTORY_DEPTH)
            lim = HISTORY_DEPTH;
        return lim;
    endfunction

    // search the held keys; on a miss append, overwriting the oldest once full
    function automatic logic predict_duplicate(input msg_key_t k);
        int lim;
        int n;
        lim = clamp_limit(limit_reg);
        n = (hist_count > lim) ? lim : hist_count;
        for (int i = 0; i < n; i++)
            if (history_keys[i] == k)
                return 1'b1;
        if (hist_wr_ptr >= lim)
            hist_wr_ptr = 0;
        history_keys[hist_wr_ptr] = k;
        hist_wr_ptr++;
        if (hist_wr_ptr >= lim)
            hist_wr_ptr = 0;
        if (hist_count < lim)
            hist_count++;
        return 1'b0;
    endfunction

    function automatic msg_key_t mk_key(input logic [SENDER_BITS-1:0] s,
                                        input logic [TYPE_W-1:0] t,
                                        input logic [ID_W-1:0] i);
        msg_key_t k;
        k.sender_id  = s;
        k.msg_type   = t;
        k.message_id = i;
        return k;
    endfunction

    function automatic void add_word(input msg_key_t k, input logic typed, input logic dup);
        stim_row_t r;
        r.kind  = ROW_WORD;
        r.limit = '0;
        r.key   = k;
        r.typed = typed;
        r.dup   = dup;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void add_limit(input logic [LIMIT_W-1:0] v);
        stim_row_t r;
        r.kind  = ROW_LIMIT;
        r.limit = v;
        r.key   = '0;
        r.typed = 1'b0;
        r.dup   = 1'b0;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // mostly repeats and near misses of recent keys, so the search hits and wraps often
    function automatic msg_key_t draw_key();
        msg_key_t k;
        int roll;
        roll = $urandom_range(99);
        if (recent_keys.size() != 0 && roll < 65) begin
            k = recent_keys[$urandom_range(recent_keys.size() - 1)];
            if (roll >= 40) begin
                case ($urandom_range(2))
                    0: k.msg_type = k.msg_type ^ TYPE_W'($urandom_range(1, 3));
                    1: k.message_id = k.message_id ^ (16'h1 << $urandom_range(ID_W - 1));
                    default: k.sender_id = k.sender_id ^ (32'h1 << $urandom_range(SENDER_BITS - 1));
                endcase
            end
        end else begin
            k.sender_id  = $urandom_range(1) ? 32'h4E303030 + $urandom_range(7) : $urandom;
            k.msg_type   = TYPE_W'($urandom_range(3));
            k.message_id = $urandom_range(1) ? ID_W'($urandom_range(15))
                                             : ID_W'($urandom_range(16'hFFFF));
        end
        return k;
    endfunction

    task automatic send_key(input msg_key_t k, input logic typed, input logic dup_typed);
        logic dup_pred;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - KEY_W){1'b0}}, k};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        dup_pred = predict_duplicate(k);
        pending_dup.insert(pending_dup.size(), typed ? dup_typed : dup_pred);
        recent_keys.insert(recent_keys.size(), k);
        if (recent_keys.size() > recent_cap)
            recent_keys.delete(0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_dup.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // only called with the block idle; any write clears the history
    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid   <= 1'b0;
        limit_reg   = v;
        hist_wr_ptr = 0;
        hist_count  = 0;
        recent_cap  = clamp_limit(v) + 4;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (holdoff_served != holdoff_requests) begin
            holdoff_served = holdoff_requests;
            holdoff_left   = holdoff_len;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dup.size() == 0) begin
                $display("%0t: result word with nothing pending, expected none, got %h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                oldest_dup = pending_dup[0];
                pending_dup.delete(0);
                if (m_tdata !== {{(OUT_TDATA_W - 1){1'b0}}, oldest_dup}) begin
                    $display("%0t: is_duplicate mismatch, expected %h got %h", $time,
                             {{(OUT_TDATA_W - 1){1'b0}}, oldest_dup}, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d results outstanding", $time, pending_dup.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        fail_count       = 0;
        gap_pct          = 0;
        stall_pct        = 0;
        holdoff_len      = 0;
        holdoff_requests = 0;
        holdoff_served   = 0;
        holdoff_left     = 0;
        limit_reg        = LIMIT_W'(LIMIT_RESET);
        hist_wr_ptr      = 0;
        hist_count       = 0;
        recent_cap       = LIMIT_RESET + 4;

        // extremes, all types, field-by-field near misses
        add_word(mk_key('0, '0, '0), 1'b1, 1'b0);
        add_word(mk_key('0, '0, '0), 1'b1, 1'b1);
        add_word(mk_key('1, '1, '1), 1'b1, 1'b0);
        add_word(mk_key('1, '1, '1), 1'b1, 1'b1);
        add_word(mk_key('1, 2'd2, '1), 1'b0, 1'b0);
        add_word(mk_key('1, '1, 16'hFFFE), 1'b0, 1'b0);
        add_word(mk_key(32'h7FFFFFFF, '1, '1), 1'b0, 1'b0);
        for (int t = 0; t < 4; t++)
            add_word(mk_key(32'h4E4F4445, TYPE_W'(t), 16'h1234), 1'b0, 1'b0);
        add_word(mk_key(32'h4E4F4445, 2'd1, 16'h1234), 1'b0, 1'b0);
        // zero limit behaves as one; the write clears what was held
        add_limit(9'd0);
        add_word(mk_key('0, '0, '0), 1'b1, 1'b0);
        add_word(mk_key('0, '0, '0), 1'b1, 1'b1);
        add_word(mk_key('1, '1, '1), 1'b1, 1'b0);
        add_word(mk_key('0, '0, '0), 1'b1, 1'b0);
        // above the depth saturates
        add_limit(9'd511);
        add_word(mk_key('1, '1, '1), 1'b1, 1'b0);
        add_word(mk_key('1, '1, '1), 1'b1, 1'b1);
        add_limit(9'd1);
        add_word(mk_key('1, '1, '1), 1'b1, 1'b0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_LIMIT) begin
                wait_drained();
                write_limit(directed_rows[r].limit);
            end else begin
                send_key(directed_rows[r].key, directed_rows[r].typed, directed_rows[r].dup);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 67; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 67; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase
            write_limit(LIMIT_W'(phase_limit[p]));
            for (int i = 0; i < phase_items[p]; i++) begin
                if (p == 2 && i == 30) begin
                    holdoff_len = 400;
                    holdoff_requests++;
                end
                if (p == 5 && i == 50)
                    wait_drained();
                send_key(draw_key(), 1'b0, 1'b0);
            end
        end

        wait_drained();
        repeat (HISTORY_DEPTH + 20) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/rmdf_pkg.sv
rtl/rmdf_ctrl.sv
rtl/rmdf_datapath.sv
rtl/recent_message_dedup_filter.sv
tb/sv/recent_message_dedup_filter_tb.sv
